// ----- hdl/gchf_pkg.sv -----
// Shared constants, payload types, state encoding and helpers for the cell height features block.
`timescale 1ns / 1ps
package gchf_pkg;

   localparam int MAX_POINTS  = 256;
   localparam int RING_COUNT  = 64;
   localparam int OUTLIER_GAP = 50;

   localparam int ADDR_W   = $clog2(MAX_POINTS);
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int SUM_W    = 16 + ADDR_W + 1;
   localparam int SZ_W     = SUM_W + 1;
   localparam int PRD_W    = 16 + CNT_W + 1;
   localparam int OD_W     = SUM_W + 3;
   localparam int ACC_W    = OD_W + ADDR_W;
   localparam int CMP_W    = ACC_W + 4;
   localparam int MN_W     = 2 * CNT_W;
   localparam int DVS_W    = CNT_W + 1;
   localparam int DIVN_W   = SZ_W + 6;
   localparam int RING_IDX_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
   localparam int RCNT_W   = $clog2(RING_COUNT + 1);
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_Z   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLLOW_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLLOW_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_THR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_RING = 3'd4;

   // cell_flags bit positions
   localparam int FLG_INVALID      = 0;
   localparam int FLG_NEAR         = 1;
   localparam int FLG_NOT_HOLLOW   = 2;
   localparam int FLG_ABOVE_DEV    = 3;
   localparam int FLG_BELOW_DEV    = 4;
   localparam int FLG_ABOVE_SENSOR = 5;
   localparam int FLG_IN_RANGE     = 6;
   localparam int FLG_OVERFLOW     = 7;

   localparam logic [DIVN_W-1:0] MEAN_POS_LIM = DIVN_W'(524287);
   localparam logic [DIVN_W-1:0] MEAN_NEG_LIM = DIVN_W'(524288);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_SLOT_DEC,
      ST_DEV,
      ST_MN,
      ST_THR,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [5:0]        ring_index;
      logic              near_range;
      logic              last_point;
   } req_payload_type;

   typedef struct packed {
      logic [8:0]         point_count;
      logic [7:0]         cell_flags;
      logic [6:0]         ring_count;
      logic signed [15:0] least_x;
      logic signed [15:0] most_x;
      logic signed [15:0] least_y;
      logic signed [15:0] most_y;
      logic signed [15:0] least_z;
      logic signed [15:0] most_z;
      logic signed [19:0] mean_x;
      logic signed [19:0] mean_y;
      logic signed [19:0] mean_z;
   } rsp_payload_type;

   // clamp a rounded magnitude to the 20-bit signed mean and apply the sign
   function automatic logic signed [19:0] sat_mean(logic [DIVN_W-1:0] q, logic neg);
      logic signed [19:0] r;
      if (!neg) begin
         r = (q > MEAN_POS_LIM) ? 20'sh7FFFF : q[19:0];
      end else begin
         r = (q > MEAN_NEG_LIM) ? 20'sh80000 : (~q[19:0] + 20'd1);
      end
      return r;
   endfunction

endpackage

// ----- hdl/gchf_zram.sv -----
// Point elevation store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module gchf_zram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [gchf_pkg::ADDR_W-1:0] wr_addr,
   input  logic signed [15:0]         wr_data,
   input  logic                       rd_en,
   input  logic [gchf_pkg::ADDR_W-1:0] rd_addr,
   output logic signed [15:0]         rd_data
);
   import gchf_pkg::*;

   logic signed [15:0] mem [MAX_POINTS];
   logic signed [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/gchf_div.sv -----
// Restoring divider, one quotient bit per cycle, for the rounded means.
`timescale 1ns / 1ps
module gchf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gchf_pkg::DIVN_W-1:0] dividend,
   input  logic [gchf_pkg::DVS_W-1:0]  divisor,
   output logic                        busy,
   output logic                        done,
   output logic [gchf_pkg::DIVN_W-1:0] quotient
);
   import gchf_pkg::*;

   localparam int REM_W = DVS_W + 1;
   localparam int ITER_W = $clog2(DIVN_W + 1);

   logic [REM_W-1:0]  rem_ff;
   logic [DIVN_W-1:0] quo_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [ITER_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff[REM_W-2:0], quo_ff[DIVN_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == ITER_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == ITER_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= ITER_W'(DIVN_W);
      end else if (busy_ff) begin
         rem_ff <= fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_ff <= {quo_ff[DIVN_W-2:0], fits};
         cnt_ff <= cnt_ff - ITER_W'(1);
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/grid_cell_height_features.sv -----
// Top level: per-cell point accumulation, outlier test, deviation pass and mean division.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  req     | in        | req_valid / req_ready  | req_payload (one point or close)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_payload (one cell summary)
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
//  Points are taken one per cycle while no cell is being closed; each accepted
//  point that still fits in the store writes its z into the elevation RAM.
//  Closing a cell runs the outlier test (n > 1) and the RAM sweep, the threshold
//  product and the three means through one shared divider, then loads the
//  summary; an empty cell goes straight to the summary.
//  Reset is synchronous; the RAM needs no clear since only entries written
//  for the current cell are read. A finished summary waits in the rsp register
//  while the next cell loads; req_ready drops only while a cell is being closed.
//
module grid_cell_height_features (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gchf_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gchf_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gchf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [19:0]                         csr_data
);
   import gchf_pkg::*;

   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

   // configuration
   logic signed [15:0] ground_z_ff;
   logic [14:0]        hollow_min_ff;
   logic [14:0]        hollow_max_ff;
   logic [19:0]        dev_thr_ff;
   logic [5:0]         upper_ring_ff;

   // cell accumulation
   logic [CNT_W-1:0]        count_ff;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [15:0]      min_x_ff, max_x_ff, min_y_ff, max_y_ff, min_z_ff, max_z_ff;
   logic signed [15:0]      prev_max_z_ff;
   logic [ADDR_W-1:0]       slot_ff;
   logic [RING_COUNT-1:0]   rings_ff;
   logic [RCNT_W-1:0]       ring_cnt_ff;
   logic                    near_ff, not_hollow_ff, ovf_ff;

   // close sequence
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        m_ff;
   logic signed [SZ_W-1:0]  sz_ff;
   logic signed [15:0]      maxz_ff;
   logic                    skip_ff;
   logic signed [PRD_W-1:0] prod_ff;
   logic signed [SZ_W-1:0]  rest_ff;
   logic [CNT_W-1:0]        idx_ff;
   logic                    rd_v_ff, p_v_ff, p_skip_ff;
   logic [ADDR_W-1:0]       rd_idx_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [MN_W-1:0]         mn_ff;
   logic [CMP_W-1:0]        thrmn_ff;
   logic                    above_ff;
   logic [1:0]              sel_ff;
   logic                    neg_ff;
   logic signed [19:0]      mean_x_ff, mean_y_ff, mean_z_ff;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // control strobes
   logic req_fire, pt_add, close_go;
   logic dev_rd, mem_rd_en, div_start, rsp_load;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic signed [15:0] mem_rd_data;

   logic div_busy, div_done;
   logic [DIVN_W-1:0] div_quo;
   logic [DIVN_W-1:0] div_dividend;
   logic [DVS_W-1:0]  div_divisor;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ground_z_ff   <= -16'sd225;
         hollow_min_ff <= 15'd50;
         hollow_max_ff <= 15'd150;
         dev_thr_ff    <= 20'd80;
         upper_ring_ff <= 6'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GROUND_Z:   ground_z_ff   <= csr_data[15:0];
            CSR_HOLLOW_MIN: hollow_min_ff <= csr_data[14:0];
            CSR_HOLLOW_MAX: hollow_max_ff <= csr_data[14:0];
            CSR_DEV_THR:    dev_thr_ff    <= csr_data;
            CSR_UPPER_RING: upper_ring_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- points
   logic signed [17:0] band_lo, band_hi, pz_ext;
   logic               ring_ok, ring_new;
   logic [RING_IDX_W-1:0] ring_sel;

   assign req_fire = req_valid && req_ready;
   assign pt_add   = req_fire && !req_payload.action && (count_ff < CNT_W'(MAX_POINTS));
   assign close_go = req_fire && (req_payload.action || req_payload.last_point);

   assign band_lo  = 18'(ground_z_ff) + 18'(hollow_min_ff);
   assign band_hi  = 18'(ground_z_ff) + 18'(hollow_max_ff);
   assign pz_ext   = 18'(req_payload.pos_z);
   assign ring_ok  = 7'(req_payload.ring_index) < 7'(RING_COUNT);
   assign ring_sel = RING_IDX_W'(req_payload.ring_index);
   assign ring_new = ring_ok && !rings_ff[ring_sel];

   always_ff @(posedge clock) begin
      if (reset || rsp_load) begin
         count_ff      <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_z_ff      <= '0;
         min_x_ff      <= '0;
         max_x_ff      <= '0;
         min_y_ff      <= '0;
         max_y_ff      <= '0;
         min_z_ff      <= '0;
         max_z_ff      <= '0;
         prev_max_z_ff <= '0;
         slot_ff       <= '0;
         rings_ff      <= '0;
         ring_cnt_ff   <= '0;
         near_ff       <= 1'b0;
         not_hollow_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (req_fire && !req_payload.action) begin
         if (!pt_add) begin
            ovf_ff <= 1'b1;   // store full: point dropped
         end else begin
            count_ff <= count_ff + CNT_W'(1);
            sum_x_ff <= sum_x_ff + SUM_W'(req_payload.pos_x);
            sum_y_ff <= sum_y_ff + SUM_W'(req_payload.pos_y);
            sum_z_ff <= sum_z_ff + SUM_W'(req_payload.pos_z);
            if (req_payload.near_range) begin
               near_ff <= 1'b1;
            end
            if (pz_ext > band_lo && pz_ext < band_hi) begin
               not_hollow_ff <= 1'b1;
            end
            if (ring_new) begin
               rings_ff[ring_sel] <= 1'b1;
               ring_cnt_ff <= ring_cnt_ff + RCNT_W'(1);
            end
            if (count_ff == '0) begin
               min_x_ff      <= req_payload.pos_x;
               max_x_ff      <= req_payload.pos_x;
               min_y_ff      <= req_payload.pos_y;
               max_y_ff      <= req_payload.pos_y;
               min_z_ff      <= req_payload.pos_z;
               max_z_ff      <= req_payload.pos_z;
               prev_max_z_ff <= req_payload.pos_z;
               slot_ff       <= '0;
            end else begin
               if (req_payload.pos_x < min_x_ff) min_x_ff <= req_payload.pos_x;
               if (req_payload.pos_x > max_x_ff) max_x_ff <= req_payload.pos_x;
               if (req_payload.pos_y < min_y_ff) min_y_ff <= req_payload.pos_y;
               if (req_payload.pos_y > max_y_ff) max_y_ff <= req_payload.pos_y;
               if (req_payload.pos_z < min_z_ff) min_z_ff <= req_payload.pos_z;
               if (req_payload.pos_z > max_z_ff) begin
                  prev_max_z_ff <= max_z_ff;
                  max_z_ff      <= req_payload.pos_z;
                  slot_ff       <= ADDR_W'(count_ff);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- RAM
   assign mem_rd_addr = (state_ff == ST_SLOT_RD) ? slot_ff : ADDR_W'(idx_ff);

   gchf_zram u_zram (
      .clock   (clock),
      .wr_en   (pt_add),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (req_payload.pos_z),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (close_go) state_in = ST_SLOT_RD;
         ST_SLOT_RD: begin
            if (count_ff == '0) begin
               state_in = ST_OUT;
            end else if (count_ff == CNT_W'(1)) begin
               state_in = ST_DEV;
            end else begin
               state_in = ST_SLOT_CHK;
            end
         end
         ST_SLOT_CHK: state_in = ST_SLOT_DEC;
         ST_SLOT_DEC: state_in = ST_DEV;
         ST_DEV:      if (idx_ff == count_ff && !rd_v_ff && !p_v_ff) state_in = ST_MN;
         ST_MN:       state_in = ST_THR;
         ST_THR:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (sel_ff == SEL_Z) ? ST_OUT : ST_DIV_GO;
            end
         end
         ST_OUT:      if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dev_rd    = 1'b0;
      mem_rd_en = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_SLOT_RD: mem_rd_en = 1'b1;
         ST_DEV: begin
            dev_rd    = idx_ff < count_ff;
            mem_rd_en = dev_rd;
         end
         ST_DIV_GO:  div_start = 1'b1;
         ST_OUT:     rsp_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_v_ff  <= 1'b0;
         p_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= dev_rd;
         p_v_ff   <= rd_v_ff;
      end
   end

   // ---------------------------------------------------------------- close datapath
   logic signed [PRD_W-1:0] mul_a, mul_b;
   logic signed [OD_W-1:0]  gap_lhs, gap_rhs, dev_d;
   logic [OD_W-1:0]         dev_abs;
   logic [CNT_W-1:0]        n_m1;

   // divider operand selection
   logic signed [SZ_W-1:0] div_op;
   logic [CNT_W-1:0]       div_d;
   logic                   div_neg;
   logic [SZ_W-1:0]        div_mag;

   assign n_m1    = count_ff - CNT_W'(1);
   // one multiplier: (n-1)*z_slot for the outlier test, m*z during the sweep
   assign mul_a   = (state_ff == ST_SLOT_CHK) ? PRD_W'({1'b0, n_m1}) : PRD_W'({1'b0, m_ff});
   assign mul_b   = PRD_W'(mem_rd_data);
   assign gap_lhs = OD_W'(prod_ff) - OD_W'(rest_ff);
   assign gap_rhs = OD_W'(OUTLIER_GAP) * OD_W'({1'b0, n_m1});
   assign dev_d   = OD_W'(prod_ff) - OD_W'(sz_ff);
   assign dev_abs = dev_d[OD_W-1] ? OD_W'(-dev_d) : OD_W'(dev_d);

   always_ff @(posedge clock) begin
      prod_ff   <= mul_a * mul_b;
      rd_idx_ff <= ADDR_W'(idx_ff);
      p_skip_ff <= skip_ff && (rd_idx_ff == slot_ff);
      case (state_ff)
         ST_SLOT_RD: begin
            m_ff    <= count_ff;
            sz_ff   <= SZ_W'(sum_z_ff);
            maxz_ff <= max_z_ff;
            skip_ff <= 1'b0;
            idx_ff  <= '0;
            acc_ff  <= '0;
            sel_ff  <= SEL_X;
         end
         ST_SLOT_CHK: rest_ff <= SZ_W'(sum_z_ff) - SZ_W'(mem_rd_data);
         ST_SLOT_DEC: begin
            if (gap_lhs >= gap_rhs) begin
               skip_ff <= 1'b1;
               m_ff    <= n_m1;
               sz_ff   <= rest_ff;
               maxz_ff <= prev_max_z_ff;
            end
         end
         ST_DEV: begin
            if (dev_rd) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
            if (p_v_ff && !p_skip_ff) begin
               acc_ff <= acc_ff + ACC_W'(dev_abs);
            end
         end
         ST_MN:  mn_ff    <= MN_W'(m_ff) * MN_W'(count_ff);
         ST_THR: thrmn_ff <= CMP_W'(dev_thr_ff) * CMP_W'(mn_ff);
         ST_DIV_GO: begin
            above_ff <= {acc_ff, 4'b0000} > thrmn_ff;
            neg_ff   <= div_neg;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (sel_ff)
                  SEL_X:   mean_x_ff <= sat_mean(div_quo, neg_ff);
                  SEL_Y:   mean_y_ff <= sat_mean(div_quo, neg_ff);
                  default: mean_z_ff <= sat_mean(div_quo, neg_ff);
               endcase
               sel_ff <= sel_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // divider operands: |16*sum| rounded half away from zero by (2|num| + d) / 2d
   always_comb begin
      case (sel_ff)
         SEL_X:   begin div_op = SZ_W'(sum_x_ff); div_d = count_ff; end
         SEL_Y:   begin div_op = SZ_W'(sum_y_ff); div_d = count_ff; end
         default: begin div_op = sz_ff;           div_d = m_ff;     end
      endcase
      div_neg      = div_op[SZ_W-1];
      div_mag      = div_neg ? SZ_W'(-div_op) : SZ_W'(div_op);
      div_dividend = {div_mag, 6'b000000} >> 1;
      div_dividend = div_dividend + DIVN_W'(div_d);
      div_divisor  = {div_d, 1'b0};
   end

   gchf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------- result
   logic [RING_COUNT-1:0] upper_rings;
   rsp_payload_type       rsp_in;

   always_comb begin
      for (int j = 0; j < RING_COUNT; j++) begin
         upper_rings[j] = rings_ff[j] && (7'(j) > {1'b0, upper_ring_ff});
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.cell_flags[FLG_IN_RANGE] = 1'b1;
      if (count_ff == '0) begin
         rsp_in.cell_flags[FLG_INVALID] = 1'b1;
      end else begin
         rsp_in.point_count                 = 9'(count_ff);
         rsp_in.cell_flags[FLG_NEAR]        = near_ff;
         rsp_in.cell_flags[FLG_NOT_HOLLOW]  = not_hollow_ff;
         rsp_in.cell_flags[FLG_OVERFLOW]    = ovf_ff;
         rsp_in.cell_flags[FLG_ABOVE_DEV]   = above_ff;
         rsp_in.cell_flags[FLG_BELOW_DEV]   = !above_ff;
         // more than one upward ring: clearing the lowest set bit leaves something
         rsp_in.cell_flags[FLG_ABOVE_SENSOR] =
            (upper_rings & (upper_rings - RING_COUNT'(1))) != '0;
         rsp_in.ring_count = 7'(ring_cnt_ff);
         rsp_in.least_x    = min_x_ff;
         rsp_in.most_x     = max_x_ff;
         rsp_in.least_y    = min_y_ff;
         rsp_in.most_y     = max_y_ff;
         rsp_in.least_z    = min_z_ff;
         rsp_in.most_z     = maxz_ff;
         rsp_in.mean_x     = mean_x_ff;
         rsp_in.mean_y     = mean_y_ff;
         rsp_in.mean_z     = mean_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store size");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (count_ff == '0 && rings_ff == '0 && !ovf_ff))
      else $error("cell state not cleared after summary");

   a_no_accept_on_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("point accepted while closing a cell");
`endif

endmodule

// ----- sim/tb_grid_cell_height_features.sv -----
// Self-checking testbench for the grid cell height features block.
`timescale 1ns / 1ps
module tb_grid_cell_height_features;
   import gchf_pkg::*;

   localparam int STALL_MAX = 18;
   localparam int IDLE_LIMIT = 4000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 400;  // one full cell close plus margin

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [19:0] csr_data = '0;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] idx;
      logic [19:0] data;
   } reg_write_type;

   req_payload_type point_q[$];      // items waiting for the driver
   rsp_payload_type summary_q[$];    // predicted cell summaries
   reg_write_type reg_q[$];

   int mismatches = 0;
   int idle_cycles = 0;

   // mirror of the block's configuration
   int cfg_ground;
   int cfg_hol_min;
   int cfg_hol_max;
   longint cfg_dev_thr;
   int cfg_upper_ring;

   // mirror of the open cell
   int cell_n;
   longint acc_x, acc_y, acc_z;
   int lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
   int prior_hi_z;
   int peak_slot;
   logic [63:0] ring_map;
   logic seen_near, seen_band, seen_ovf;
   int z_mem [MAX_POINTS];

   grid_cell_height_features dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // queue helpers
   function automatic void enq_point(req_payload_type p);
      point_q = {point_q, p};
   endfunction

   function automatic void enq_reg(logic [CSR_IDX_W-1:0] idx, logic [19:0] data);
      reg_write_type w;
      w.idx = idx;
      w.data = data;
      reg_q = {reg_q, w};
   endfunction

   // ---------------------------------------------------------------
   // Cell predictor
   // ---------------------------------------------------------------
   function automatic void clear_cell();
      cell_n = 0;
      acc_x = 0; acc_y = 0; acc_z = 0;
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
      prior_hi_z = 0;
      peak_slot = 0;
      ring_map = '0;
      seen_near = 1'b0; seen_band = 1'b0; seen_ovf = 1'b0;
   endfunction

   function automatic void reset_config();
      cfg_ground = -225;
      cfg_hol_min = 50;
      cfg_hol_max = 150;
      cfg_dev_thr = 80;
      cfg_upper_ring = 16;
   endfunction

   function automatic void apply_reg(reg_write_type w);
      case (w.idx)
         CSR_GROUND_Z: begin
            cfg_ground = int'($signed(w.data[15:0]));
         end
         CSR_HOLLOW_MIN: begin
            cfg_hol_min = int'(w.data[14:0]);
         end
         CSR_HOLLOW_MAX: begin
            cfg_hol_max = int'(w.data[14:0]);
         end
         CSR_DEV_THR: begin
            cfg_dev_thr = longint'(w.data);
         end
         CSR_UPPER_RING: begin
            cfg_upper_ring = int'(w.data[5:0]);
         end
         default: begin
         end
      endcase
   endfunction

   // 16 * sum / d, rounded half away from zero, clamped to 20 bits
   function automatic logic signed [19:0] fixed_mean(longint sum, longint d);
      longint num;
      longint q;
      num = sum * 16;
      if (num >= 0) q = (2 * num + d) / (2 * d);
      else q = -((-2 * num + d) / (2 * d));
      if (q > 524287) q = 524287;
      if (q < -524288) q = -524288;
      return q[19:0];
   endfunction

   function automatic void add_point(req_payload_type p);
      int x, y, z;
      x = int'(p.pos_x);
      y = int'(p.pos_y);
      z = int'(p.pos_z);
      if (cell_n >= MAX_POINTS) begin
         seen_ovf = 1'b1;          // store full: only the flag survives
         return;
      end
      acc_x += x; acc_y += y; acc_z += z;
      if (p.near_range) seen_near = 1'b1;
      if (int'(p.ring_index) < RING_COUNT) ring_map[p.ring_index] = 1'b1;
      if (z > cfg_ground + cfg_hol_min && z < cfg_ground + cfg_hol_max) seen_band = 1'b1;
      if (cell_n == 0) begin
         lo_x = x; hi_x = x; lo_y = y; hi_y = y; lo_z = z; hi_z = z;
         prior_hi_z = z;
         peak_slot = 0;
      end else begin
         if (x < lo_x) lo_x = x;
         if (x > hi_x) hi_x = x;
         if (y < lo_y) lo_y = y;
         if (y > hi_y) hi_y = y;
         if (z < lo_z) lo_z = z;
         if (z > hi_z) begin
            prior_hi_z = hi_z;
            hi_z = z;
            peak_slot = cell_n;
         end
      end
      z_mem[cell_n] = z;
      cell_n++;
   endfunction

   function automatic rsp_payload_type summarize_cell();
      rsp_payload_type r;
      longint n, m, sz, zo, rest, dev, d;
      logic drop;
      logic [63:0] upper;
      r = '0;
      r.cell_flags[FLG_IN_RANGE] = 1'b1;
      if (cell_n == 0) begin
         r.cell_flags[FLG_INVALID] = 1'b1;
         return r;
      end
      n = cell_n;
      m = n;
      sz = acc_z;
      drop = 1'b0;
      r.most_z = hi_z[15:0];
      // highest point is an outlier if it sits at least OUTLIER_GAP above the others' mean
      if (n > 1) begin
         zo = z_mem[peak_slot];
         rest = sz - zo;
         if ((n - 1) * zo - rest >= OUTLIER_GAP * (n - 1)) begin
            drop = 1'b1;
            r.most_z = prior_hi_z[15:0];
            m = n - 1;
            sz = rest;
         end
      end
      dev = 0;
      for (int i = 0; i < cell_n; i++) begin
         if (!(drop && i == peak_slot)) begin
            d = m * z_mem[i] - sz;
            dev += (d < 0) ? -d : d;
         end
      end
      if (dev * 16 > cfg_dev_thr * m * n) r.cell_flags[FLG_ABOVE_DEV] = 1'b1;
      else r.cell_flags[FLG_BELOW_DEV] = 1'b1;
      upper = (cfg_upper_ring >= 63) ? 64'd0 :
              ring_map & ~((64'd1 << (cfg_upper_ring + 1)) - 64'd1);
      r.cell_flags[FLG_ABOVE_SENSOR] = ($countones(upper) > 1);
      r.cell_flags[FLG_NEAR] = seen_near;
      r.cell_flags[FLG_NOT_HOLLOW] = seen_band;
      r.cell_flags[FLG_OVERFLOW] = seen_ovf;
      r.point_count = n[8:0];
      r.ring_count = 7'($countones(ring_map));
      r.least_x = lo_x[15:0];
      r.most_x = hi_x[15:0];
      r.least_y = lo_y[15:0];
      r.most_y = hi_y[15:0];
      r.least_z = lo_z[15:0];
      r.mean_x = fixed_mean(acc_x, n);
      r.mean_y = fixed_mean(acc_y, n);
      r.mean_z = fixed_mean(sz, m);
      return r;
   endfunction

   function automatic void predict_item(req_payload_type p);
      if (!p.action) begin
         add_point(p);
         if (!p.last_point) return;
      end
      summary_q = {summary_q, summarize_cell()};
      clear_cell();
   endfunction

   // ---------------------------------------------------------------
   // Request driver: one item in flight, random gap drawn per item,
   // with every other run of 64 items sent back to back.
   // ---------------------------------------------------------------
   int req_gap = 0;
   int req_sent = 0;

   always @(posedge clock) begin
      logic took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            predict_item(req_payload);
            req_sent++;
            req_gap = ((req_sent / 64) % 2) ? 0 : $urandom_range(0, STALL_MAX);
         end
         if (!req_valid || took) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (point_q.size() > 0) begin
               req_payload <= point_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Register write driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      reg_write_type w;
      logic took;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         took = csr_valid && csr_ready;
         if (took) apply_reg('{idx: csr_index, data: csr_data});
         if (!csr_valid || took) begin
            if (reg_q.size() > 0) begin
               w = reg_q.pop_front();
               csr_index <= w.idx;
               csr_data <= w.data;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor: random stalls in every other run of 8, compare each field
   // ---------------------------------------------------------------
   int rsp_stall = 0;
   int rsp_seen = 0;

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("cell %0d %s: expected %0h got %0h", rsp_seen, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("cell %0d: summary with none expected", rsp_seen);
            end else begin
               e = summary_q.pop_front();
               check_field("point_count", e.point_count, rsp_payload.point_count);
               check_field("cell_flags", e.cell_flags, rsp_payload.cell_flags);
               check_field("ring_count", e.ring_count, rsp_payload.ring_count);
               check_field("least_x", e.least_x, rsp_payload.least_x);
               check_field("most_x", e.most_x, rsp_payload.most_x);
               check_field("least_y", e.least_y, rsp_payload.least_y);
               check_field("most_y", e.most_y, rsp_payload.most_y);
               check_field("least_z", e.least_z, rsp_payload.least_z);
               check_field("most_z", e.most_z, rsp_payload.most_z);
               check_field("mean_x", e.mean_x, rsp_payload.mean_x);
               check_field("mean_y", e.mean_y, rsp_payload.mean_y);
               check_field("mean_z", e.mean_z, rsp_payload.mean_z);
            end
            rsp_seen++;
            rsp_stall = ((rsp_seen / 8) % 2) ? 0 : $urandom_range(0, STALL_MAX);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: any handshake resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("grid_cell_height_features: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic req_payload_type mk_point(int x, int y, int z, int ring,
                                                bit near, bit last);
      req_payload_type p;
      p.action = 1'b0;
      p.pos_x = x[15:0];
      p.pos_y = y[15:0];
      p.pos_z = z[15:0];
      p.ring_index = ring[5:0];
      p.near_range = near;
      p.last_point = last;
      return p;
   endfunction

   function automatic req_payload_type mk_close();
      req_payload_type p;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      p = noise[$bits(req_payload_type)-1:0];
      p.action = 1'b1;        // other fields are don't-care
      return p;
   endfunction

   // one cell: points scattered around a base, z mostly near ground so the
   // hollow band and the deviation threshold both get exercised
   task automatic queue_cell(int n, bit by_close);
      int bx, by, bz, spread, spike;
      bit wide;
      wide = ($urandom_range(0, 7) == 0);
      bx = $urandom_range(0, 65535) - 32768;
      by = $urandom_range(0, 65535) - 32768;
      bz = cfg_ground + $urandom_range(0, 200) - 50;
      spread = 1 << $urandom_range(0, 8);
      spike = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : -1;
      for (int i = 0; i < n; i++) begin
         int x, y, z;
         if (wide) begin
            x = $urandom_range(0, 65535) - 32768;
            y = $urandom_range(0, 65535) - 32768;
            z = $urandom_range(0, 65535) - 32768;
         end else begin
            x = bx + $urandom_range(0, 400) - 200;
            y = by + $urandom_range(0, 400) - 200;
            z = bz + $urandom_range(0, spread) - spread / 2;
            if (i == spike) z = z + $urandom_range(20, 400);
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            if (z > 32767) z = 32767;
            if (z < -32768) z = -32768;
         end
         enq_point(mk_point(x, y, z, $urandom_range(0, 63),
                            ($urandom_range(0, 5) == 0),
                            (i == n - 1) && !by_close));
      end
      if (by_close || n == 0) enq_point(mk_close());
   endtask

   task automatic queue_random(int budget);
      int n;
      while (budget > 0) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         queue_cell(n, ($urandom_range(0, 4) == 0));
         budget -= (n == 0) ? 1 : n;
      end
   endtask

   // block goes idle: all items sent, all summaries back, then a short pause
   task automatic wait_idle();
      wait (point_q.size() == 0 && !req_valid && summary_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(int gz, int hmin, int hmax, int thr, int ur);
      enq_reg(CSR_GROUND_Z, 20'(gz));
      enq_reg(CSR_HOLLOW_MIN, 20'(hmin));
      enq_reg(CSR_HOLLOW_MAX, 20'(hmax));
      enq_reg(CSR_DEV_THR, 20'(thr));
      enq_reg(CSR_UPPER_RING, 20'(ur));
      wait (reg_q.size() == 0 && !csr_valid);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      reset_config();
      clear_cell();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cell, extremes, outlier, close by action, rings
      enq_point(mk_close());
      enq_point(mk_point(-32768, 32767, -32768, 0, 1'b1, 1'b1));
      enq_point(mk_point(32767, -32768, 32767, 63, 1'b0, 1'b0));
      enq_point(mk_point(-32768, 32767, -32768, 62, 1'b1, 1'b1));
      enq_point(mk_point(0, 0, 0, 17, 1'b0, 1'b0));
      enq_point(mk_point(1, 1, 0, 18, 1'b0, 1'b0));
      enq_point(mk_point(2, 2, 0, 16, 1'b0, 1'b0));
      enq_point(mk_point(3, 3, 100, 40, 1'b0, 1'b1));   // outlier
      enq_point(mk_point(5, 5, -100, 1, 1'b0, 1'b0));
      enq_point(mk_point(6, 6, -51, 2, 1'b1, 1'b0));   // gap just under
      enq_point(mk_close());
      enq_point(mk_point(7, -7, -200, 20, 1'b0, 1'b0));   // below the hollow band
      enq_point(mk_point(-7, 7, -150, 20, 1'b0, 1'b0));   // gap exactly 50
      enq_point(mk_close());
      enq_point(mk_close());
      wait_idle();

      queue_random(70);
      wait_idle();

      // extremes of every register
      set_regs(-32768, 32767, 32767, 0, 63);
      queue_random(60);
      wait_idle();

      set_regs(32767, 0, 0, 1048575, 0);
      queue_random(50);
      queue_cell(MAX_POINTS + 2, 1'b0);         // fills the store, then overflow
      wait_idle();

      set_regs($urandom_range(0, 600) - 400, $urandom_range(0, 100),
               $urandom_range(100, 400), $urandom_range(0, 400), $urandom_range(0, 40));
      queue_random(70);
      wait_idle();

      if (mismatches == 0) begin
         $display("grid_cell_height_features: match");
      end else begin
         $display("grid_cell_height_features: mismatch");
      end
      $finish;
   end

endmodule

// ----- grid_cell_height_features.f -----
hdl/gchf_pkg.sv
hdl/gchf_zram.sv
hdl/gchf_div.sv
hdl/grid_cell_height_features.sv
sim/tb_grid_cell_height_features.sv
